@@ design/rbsi_pkg.sv @@
// rbsi_pkg: widths, constants and payload types of the ray/box slab intersect block
// used by every module of the block, depends on nothing
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;                 // coordinate width
  localparam int HALF_W    = 31;                 // half size width
  localparam int NW        = W + 2;              // slab distance, signed
  localparam int NMAG_W    = NW - 1;             // slab distance magnitude
  localparam int NUM_W     = NMAG_W + FRAC_BITS; // scaled dividend, quotient magnitude
  localparam int T_W       = NUM_W + 1;          // signed crossing parameter
  localparam int DVS_W     = W;                  // divisor magnitude
  localparam int LO_W      = (NUM_W + 1) / 2;    // low part of the split multiply
  localparam int HI_W      = NUM_W - LO_W;
  localparam int PROD_W    = W + NUM_W + 1;      // dir * entry
  localparam int HP_W      = PROD_W - FRAC_BITS + 1; // unsaturated hit point
  localparam int MAG_W     = 33;                 // clamped face distance
  localparam int LR_W      = MAG_W + HALF_W;     // face cross products
  localparam int FQ_DEPTH  = 4;
  localparam int FQ_AW     = $clog2(FQ_DEPTH);

  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

  // ray and box as taken in, plus per-axis classification
  typedef struct packed {
    logic [2:0][W-1:0]      org;
    logic [2:0][W-1:0]      dir;
    logic [2:0][W-1:0]      ctr;
    logic [2:0][HALF_W-1:0] half;
    logic [2:0]             dz;      // zero direction component
    logic                   outside; // origin outside a slab with zero direction
  } side_t;

  // queue entry between front and back
  typedef struct packed {
    logic [2:0][T_W-1:0] tlo;
    logic [2:0][T_W-1:0] thi;
    side_t               side;
  } fq_t;

  // payload carried through the face compare stages
  typedef struct packed {
    logic                   hit;
    logic [30:0]            et;
    logic [2:0][W-1:0]      hs;
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0]             dneg;
    logic [2:0][HALF_W-1:0] half;
  } bk_t;

  // running best ratio and face mask
  typedef struct packed {
    logic [MAG_W-1:0]  bn;
    logic [HALF_W-1:0] bd;
    logic [2:0]        ax;
    logic [2:0]        sg;
  } fc_t;

endpackage

@@ design/rbsi_div.sv @@
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// depends on rbsi_pkg
module rbsi_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rbsi_pkg::NUM_W-1:0] num_i,
  input  logic [rbsi_pkg::DVS_W-1:0] dvs_i,
  input  logic                        neg_i,
  output logic [rbsi_pkg::NUM_W-1:0] quo_o,
  output logic                        neg_o
);

  logic [rbsi_pkg::DVS_W-1:0] rem_q [rbsi_pkg::NUM_W];
  logic [rbsi_pkg::NUM_W-1:0] num_q [rbsi_pkg::NUM_W];
  logic [rbsi_pkg::NUM_W-1:0] quo_q [rbsi_pkg::NUM_W];
  logic [rbsi_pkg::DVS_W-1:0] dvs_q [rbsi_pkg::NUM_W];
  logic                       neg_q [rbsi_pkg::NUM_W];

  for (genvar k = 0; k < rbsi_pkg::NUM_W; k++) begin : g_stage
    logic [rbsi_pkg::DVS_W-1:0] r_in, d_in, trial, r_nx;
    logic [rbsi_pkg::NUM_W-1:0] n_in, q_in;
    logic                       s_in, ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = dvs_i;
      assign s_in = neg_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = dvs_q[k-1];
      assign s_in = neg_q[k-1];
    end

    // remainder stays below the divisor, so its top bit is free
    assign trial = {r_in[rbsi_pkg::DVS_W-2:0], n_in[rbsi_pkg::NUM_W-1]};
    assign ge    = trial >= d_in;
    assign r_nx  = ge ? trial - d_in : trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= r_nx;
        num_q[k] <= {n_in[rbsi_pkg::NUM_W-2:0], 1'b0};
        quo_q[k] <= {q_in[rbsi_pkg::NUM_W-2:0], ge};
        dvs_q[k] <= d_in;
        neg_q[k] <= s_in;
      end
    end
  end

  assign quo_o = quo_q[rbsi_pkg::NUM_W-1];
  assign neg_o = neg_q[rbsi_pkg::NUM_W-1];

endmodule

@@ design/rbsi_front.sv @@
// rbsi_front: slab distances, zero direction classification and six crossing divisions
// depends on rbsi_pkg and rbsi_div
module rbsi_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           origin_x_i,
  input  logic signed [31:0]           origin_y_i,
  input  logic signed [31:0]           origin_z_i,
  input  logic signed [31:0]           dir_x_i,
  input  logic signed [31:0]           dir_y_i,
  input  logic signed [31:0]           dir_z_i,
  input  logic signed [31:0]           center_x_i,
  input  logic signed [31:0]           center_y_i,
  input  logic signed [31:0]           center_z_i,
  input  logic [30:0]                  half_x_i,
  input  logic [30:0]                  half_y_i,
  input  logic [30:0]                  half_z_i,
  output logic                         fq_push_o,
  output rbsi_pkg::fq_t                fq_data_o,
  input  logic                         fq_full_i
);

  logic                             en;
  logic                             s0_v_q, s1_v_q, fo_v_q;
  logic [rbsi_pkg::NUM_W-1:0]       dv_q;
  rbsi_pkg::side_t                  side0_d, side0_q, side1_d, side1_q;
  rbsi_pkg::side_t                  dl_q [rbsi_pkg::NUM_W];
  logic [2:0][rbsi_pkg::NW-1:0]     nlo_d, nhi_d, nlo_q, nhi_q;
  logic [2:0][rbsi_pkg::NMAG_W-1:0] mlo_d, mhi_d, mlo_q, mhi_q;
  logic [2:0]                       slo_d, shi_d, slo_q, shi_q;
  logic [2:0][rbsi_pkg::DVS_W-1:0]  dvs_d, dvs_q;
  logic [2:0][rbsi_pkg::NUM_W-1:0]  qlo, qhi;
  logic [2:0]                       qslo, qshi;
  logic [2:0]                       outax;
  rbsi_pkg::fq_t                    fo_d, fo_q;

  assign en         = !fo_v_q || !fq_full_i;
  assign in_ready_o = en;
  assign fq_push_o  = fo_v_q && !fq_full_i;
  assign fq_data_o  = fo_q;

  always_comb begin
    side0_d         = '0;
    side0_d.org[0]  = origin_x_i;
    side0_d.org[1]  = origin_y_i;
    side0_d.org[2]  = origin_z_i;
    side0_d.dir[0]  = dir_x_i;
    side0_d.dir[1]  = dir_y_i;
    side0_d.dir[2]  = dir_z_i;
    side0_d.ctr[0]  = center_x_i;
    side0_d.ctr[1]  = center_y_i;
    side0_d.ctr[2]  = center_z_i;
    side0_d.half[0] = half_x_i;
    side0_d.half[1] = half_y_i;
    side0_d.half[2] = half_z_i;
    for (int i = 0; i < 3; i++) begin
      nlo_d[i] = {{2{side0_d.ctr[i][31]}}, side0_d.ctr[i]} - {3'b000, side0_d.half[i]}
               - {{2{side0_d.org[i][31]}}, side0_d.org[i]};
      nhi_d[i] = {{2{side0_d.ctr[i][31]}}, side0_d.ctr[i]} + {3'b000, side0_d.half[i]}
               - {{2{side0_d.org[i][31]}}, side0_d.org[i]};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [rbsi_pkg::NW-1:0]    nl_neg, nh_neg;
    logic [rbsi_pkg::DVS_W-1:0] d_neg;
    logic                       nl_s, nh_s, d_s;

    assign nl_s     = nlo_q[i][rbsi_pkg::NW-1];
    assign nh_s     = nhi_q[i][rbsi_pkg::NW-1];
    assign d_s      = side0_q.dir[i][31];
    assign nl_neg   = -nlo_q[i];
    assign nh_neg   = -nhi_q[i];
    assign d_neg    = -side0_q.dir[i];
    assign mlo_d[i] = nl_s ? nl_neg[rbsi_pkg::NMAG_W-1:0] : nlo_q[i][rbsi_pkg::NMAG_W-1:0];
    assign mhi_d[i] = nh_s ? nh_neg[rbsi_pkg::NMAG_W-1:0] : nhi_q[i][rbsi_pkg::NMAG_W-1:0];
    assign slo_d[i] = nl_s ^ d_s;
    assign shi_d[i] = nh_s ^ d_s;
    assign dvs_d[i] = d_s ? d_neg : side0_q.dir[i];
    // both slab planes on the same side of the origin
    assign outax[i] = (!nl_s && |nlo_q[i] && !nh_s && |nhi_q[i]) || (nl_s && nh_s);

    rbsi_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({mlo_q[i], {rbsi_pkg::FRAC_BITS{1'b0}}}),
      .dvs_i (dvs_q[i]),
      .neg_i (slo_q[i]),
      .quo_o (qlo[i]),
      .neg_o (qslo[i])
    );

    rbsi_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({mhi_q[i], {rbsi_pkg::FRAC_BITS{1'b0}}}),
      .dvs_i (dvs_q[i]),
      .neg_i (shi_q[i]),
      .quo_o (qhi[i]),
      .neg_o (qshi[i])
    );
  end

  always_comb begin
    side1_d = side0_q;
    for (int i = 0; i < 3; i++) begin
      side1_d.dz[i] = side0_q.dir[i] == '0;
    end
    side1_d.outside = |(side1_d.dz & outax);
  end

  always_comb begin
    fo_d      = '0;
    fo_d.side = dl_q[rbsi_pkg::NUM_W-1];
    for (int i = 0; i < 3; i++) begin
      fo_d.tlo[i] = qslo[i] ? -{1'b0, qlo[i]} : {1'b0, qlo[i]};
      fo_d.thi[i] = qshi[i] ? -{1'b0, qhi[i]} : {1'b0, qhi[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q  <= side0_d;
      nlo_q    <= nlo_d;
      nhi_q    <= nhi_d;
      side1_q  <= side1_d;
      mlo_q    <= mlo_d;
      mhi_q    <= mhi_d;
      slo_q    <= slo_d;
      shi_q    <= shi_d;
      dvs_q    <= dvs_d;
      dl_q[0]  <= side1_q;
      for (int k = 1; k < rbsi_pkg::NUM_W; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      fo_q     <= fo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      dv_q   <= '0;
      fo_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      dv_q   <= {dv_q[rbsi_pkg::NUM_W-2:0], s1_v_q};
      fo_v_q <= dv_q[rbsi_pkg::NUM_W-1];
    end
  end

endmodule

@@ design/rbsi_fifo.sv @@
// rbsi_fifo: short request queue between front and back
// depends on rbsi_pkg
module rbsi_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbsi_pkg::fq_t data_i,
  input  logic          pop_i,
  output rbsi_pkg::fq_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  rbsi_pkg::fq_t               mem_q [rbsi_pkg::FQ_DEPTH];
  logic [rbsi_pkg::FQ_AW-1:0]  wp_q, rp_q;
  logic [rbsi_pkg::FQ_AW:0]    cnt_q;

  assign full_o  = cnt_q == rbsi_pkg::FQ_DEPTH;
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + {{rbsi_pkg::FQ_AW{1'b0}}, push_i} - {{rbsi_pkg::FQ_AW{1'b0}}, pop_i};
    end
  end

endmodule

@@ design/rbsi_back.sv @@
// rbsi_back: entry/exit reduction, hit point, face selection and output register
// depends on rbsi_pkg
module rbsi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbsi_pkg::fq_t       fq_data_i,
  input  logic                fq_empty_i,
  output logic                fq_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [30:0]         entry_t_o,
  output logic signed [31:0]  hit_x_o,
  output logic signed [31:0]  hit_y_o,
  output logic signed [31:0]  hit_z_o,
  output logic [2:0]          face_axes_o,
  output logic [2:0]          face_signs_o
);

  logic en;
  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q, b6_v_q, ov_q;

  // b1: near and far crossing per axis
  rbsi_pkg::side_t              s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [2:0][rbsi_pkg::T_W-1:0] tn_d, tf_d, tn_q, tf_q;
  // b2: entry and exit
  logic [rbsi_pkg::T_W-1:0]     ent_d, ext_d, ent_q, ext_q;
  // b3: hit decision
  logic                         hit_d, hit3_q, hit4_q, hit5_q, hit6_q;
  logic [rbsi_pkg::NUM_W-1:0]   e_q;
  logic [30:0]                  et_d, et3_q, et4_q, et5_q, et6_q;
  // b4: split products
  logic signed [2:0][rbsi_pkg::W+rbsi_pkg::LO_W:0] plo_q;
  logic signed [2:0][rbsi_pkg::W+rbsi_pkg::HI_W:0] phi_q;
  logic signed [rbsi_pkg::W+rbsi_pkg::LO_W:0] plo_d [3];
  logic signed [rbsi_pkg::W+rbsi_pkg::HI_W:0] phi_d [3];
  // b5: full product
  logic [2:0][rbsi_pkg::PROD_W-1:0] prod_d, prod_q;
  // b6: unsaturated hit point
  logic [2:0][rbsi_pkg::HP_W-1:0]   hp_d, hp_q;
  // b7 and face stages
  rbsi_pkg::bk_t cp_d;
  rbsi_pkg::fc_t cs_d;
  rbsi_pkg::bk_t cp_q [4];
  rbsi_pkg::fc_t cs_q [4];
  logic          cv_q [4];

  assign en       = !ov_q || out_ready_i;
  assign fq_pop_o = en && !fq_empty_i;

  // zero direction axes do not bound the interval
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fq_data_i.side.dz[i]) begin
        tn_d[i] = rbsi_pkg::T_MIN;
        tf_d[i] = rbsi_pkg::T_MAX;
      end else if ($signed(fq_data_i.tlo[i]) < $signed(fq_data_i.thi[i])) begin
        tn_d[i] = fq_data_i.tlo[i];
        tf_d[i] = fq_data_i.thi[i];
      end else begin
        tn_d[i] = fq_data_i.thi[i];
        tf_d[i] = fq_data_i.tlo[i];
      end
    end
  end

  always_comb begin
    logic n01, n02, n12, f01, f02, f12;
    n01 = $signed(tn_q[0]) >= $signed(tn_q[1]);
    n02 = $signed(tn_q[0]) >= $signed(tn_q[2]);
    n12 = $signed(tn_q[1]) >= $signed(tn_q[2]);
    f01 = $signed(tf_q[0]) <= $signed(tf_q[1]);
    f02 = $signed(tf_q[0]) <= $signed(tf_q[2]);
    f12 = $signed(tf_q[1]) <= $signed(tf_q[2]);
    ent_d = (n01 && n02) ? tn_q[0] : (n12 ? tn_q[1] : tn_q[2]);
    ext_d = (f01 && f02) ? tf_q[0] : (f12 ? tf_q[1] : tf_q[2]);
  end

  // entry must be strictly positive and strictly before exit
  assign hit_d = !s2_q.outside && !ent_q[rbsi_pkg::T_W-1] && (|ent_q)
              && ($signed(ent_q) < $signed(ext_q));
  assign et_d  = (|ent_q[rbsi_pkg::NUM_W-1:31]) ? 31'h7fff_ffff : ent_q[30:0];

  // e_q travels with s3_q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      plo_d[i] = $signed(s3_q.dir[i]) * $signed({1'b0, e_q[rbsi_pkg::LO_W-1:0]});
      phi_d[i] = $signed(s3_q.dir[i]) * $signed({1'b0, e_q[rbsi_pkg::NUM_W-1:rbsi_pkg::LO_W]});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = {{(rbsi_pkg::PROD_W-rbsi_pkg::W-rbsi_pkg::LO_W-1)
                    {plo_q[i][rbsi_pkg::W+rbsi_pkg::LO_W]}}, plo_q[i]}
                + ({{(rbsi_pkg::PROD_W-rbsi_pkg::W-rbsi_pkg::HI_W-1)
                     {phi_q[i][rbsi_pkg::W+rbsi_pkg::HI_W]}}, phi_q[i]} << rbsi_pkg::LO_W);
    end
  end

  // dropping the fraction bits of a two's complement value is a floor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hp_d[i] = {{(rbsi_pkg::HP_W-rbsi_pkg::W){s5_q.org[i][31]}}, s5_q.org[i]}
              + {prod_q[i][rbsi_pkg::PROD_W-1], prod_q[i][rbsi_pkg::PROD_W-1:rbsi_pkg::FRAC_BITS]};
    end
  end

  always_comb begin
    logic [rbsi_pkg::HP_W-1:0] cx, df, nd, mg;
    logic                      sg, hi_or, hi_and;
    cp_d      = '0;
    cp_d.hit  = hit6_q;
    cp_d.et   = et6_q;
    cp_d.half = s6_q.half;
    for (int i = 0; i < 3; i++) begin
      cx     = {{(rbsi_pkg::HP_W-rbsi_pkg::W){s6_q.ctr[i][31]}}, s6_q.ctr[i]};
      df     = hp_q[i] - cx;
      nd     = cx - hp_q[i];
      sg     = df[rbsi_pkg::HP_W-1];
      mg     = sg ? nd : df;
      cp_d.dneg[i] = sg;
      cp_d.mag[i]  = (|mg[rbsi_pkg::HP_W-1:rbsi_pkg::MAG_W]) ? '1 : mg[rbsi_pkg::MAG_W-1:0];
      hi_or  = |hp_q[i][rbsi_pkg::HP_W-2:31];
      hi_and = &hp_q[i][rbsi_pkg::HP_W-2:31];
      if (!hp_q[i][rbsi_pkg::HP_W-1] && hi_or) begin
        cp_d.hs[i] = 32'h7fff_ffff;
      end else if (hp_q[i][rbsi_pkg::HP_W-1] && !hi_and) begin
        cp_d.hs[i] = 32'h8000_0000;
      end else begin
        cp_d.hs[i] = hp_q[i][31:0];
      end
    end
    cs_d    = '0;
    cs_d.bd = {{(rbsi_pkg::HALF_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= fq_data_i.side;
      tn_q   <= tn_d;
      tf_q   <= tf_d;
      s2_q   <= s1_q;
      ent_q  <= ent_d;
      ext_q  <= ext_d;
      s3_q   <= s2_q;
      hit3_q <= hit_d;
      e_q    <= ent_q[rbsi_pkg::NUM_W-1:0];
      et3_q  <= et_d;
      s4_q   <= s3_q;
      hit4_q <= hit3_q;
      et4_q  <= et3_q;
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= plo_d[i];
        phi_q[i] <= phi_d[i];
      end
      s5_q   <= s4_q;
      hit5_q <= hit4_q;
      et5_q  <= et4_q;
      prod_q <= prod_d;
      s6_q   <= s5_q;
      hit6_q <= hit5_q;
      et6_q  <= et5_q;
      hp_q   <= hp_d;
      cp_q[0] <= cp_d;
      cs_q[0] <= cs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      b5_v_q  <= 1'b0;
      b6_v_q  <= 1'b0;
      cv_q[0] <= 1'b0;
    end else if (en) begin
      b1_v_q  <= !fq_empty_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      b5_v_q  <= b4_v_q;
      b6_v_q  <= b5_v_q;
      cv_q[0] <= b6_v_q;
    end
  end

  // one axis per pair of stages: cross products, then compare and update
  for (genvar i = 0; i < 3; i++) begin : g_face
    rbsi_pkg::bk_t            mp_q;
    rbsi_pkg::fc_t            ms_q, ns_d;
    logic                     mv_q;
    logic [rbsi_pkg::LR_W-1:0] l_q, r_q;

    always_comb begin
      ns_d = ms_q;
      if (l_q > r_q) begin
        ns_d.ax = 3'(1 << i);
        ns_d.sg = mp_q.dneg[i] ? 3'(1 << i) : 3'b000;
        ns_d.bn = mp_q.mag[i];
        ns_d.bd = mp_q.half[i];
      end else if (l_q == r_q) begin
        ns_d.ax[i] = 1'b1;
        if (mp_q.dneg[i]) begin
          ns_d.sg[i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mp_q      <= cp_q[i];
        ms_q      <= cs_q[i];
        l_q       <= cp_q[i].mag[i] * cs_q[i].bd;
        r_q       <= cs_q[i].bn * cp_q[i].half[i];
        cp_q[i+1] <= mp_q;
        cs_q[i+1] <= ns_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q      <= 1'b0;
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        mv_q      <= cv_q[i];
        cv_q[i+1] <= mv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o        <= cp_q[3].hit;
      entry_t_o    <= cp_q[3].hit ? cp_q[3].et : '0;
      hit_x_o      <= cp_q[3].hit ? cp_q[3].hs[0] : '0;
      hit_y_o      <= cp_q[3].hit ? cp_q[3].hs[1] : '0;
      hit_z_o      <= cp_q[3].hit ? cp_q[3].hs[2] : '0;
      face_axes_o  <= cp_q[3].hit ? cs_q[3].ax : '0;
      face_signs_o <= cp_q[3].hit ? cs_q[3].sg : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= cv_q[3];
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ design/ray_box_slab_intersect.sv @@
// ray against axis-aligned box, slab test, Q16.16 fixed point in box-local space
// throughput one request per cycle, set by the bit-per-stage crossing dividers,
// while the front is not stalled by a full queue
// rst_ni clears all valid bits and queue pointers, payload registers are not reset
// depends on rbsi_pkg, rbsi_front, rbsi_fifo, rbsi_back
module ray_box_slab_intersect (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        half_x_i,
  input  logic [30:0]        half_y_i,
  input  logic [30:0]        half_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [30:0]        entry_t_o,
  output logic signed [31:0] hit_x_o,
  output logic signed [31:0] hit_y_o,
  output logic signed [31:0] hit_z_o,
  output logic [2:0]         face_axes_o,
  output logic [2:0]         face_signs_o
);

  // front: slab distances, zero direction check, six crossing divisions
  // it stalls only when its last stage holds a request and the queue is full
  logic          fq_push, fq_pop, fq_full, fq_empty;
  rbsi_pkg::fq_t fq_wdata, fq_rdata;

  rbsi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .center_z_i (center_z_i),
    .half_x_i   (half_x_i),
    .half_y_i   (half_y_i),
    .half_z_i   (half_z_i),
    .fq_push_o  (fq_push),
    .fq_data_o  (fq_wdata),
    .fq_full_i  (fq_full)
  );

  // queue decouples the divider pipeline from output back-pressure
  rbsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .full_o  (fq_full),
    .empty_o (fq_empty)
  );

  // back: entry/exit, hit decision, split multiply for the hit point,
  // exact face compare by cross products, then the output register
  rbsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fq_data_i    (fq_rdata),
    .fq_empty_i   (fq_empty),
    .fq_pop_o     (fq_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .entry_t_o    (entry_t_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o),
    .hit_z_o      (hit_z_o),
    .face_axes_o  (face_axes_o),
    .face_signs_o (face_signs_o)
  );

endmodule

@@ verif/ray_box_slab_intersect_tb.sv @@
// testbench for ray_box_slab_intersect: directed table then shaped random requests,
// results checked against typed table rows or a slab-test predictor; depends on rbsi_pkg
module ray_box_slab_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q         = 65536;   // one in Q16.16
  localparam int N_RANDOM  = 480;
  localparam int QUIET_AT  = 420;     // no idling once this many requests went in
  localparam int HOLD_AT   = 150;     // request count that starts the long receiver hold
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN     = 200;     // cycles waited past the last result
  localparam int LIMIT     = 200000;

  typedef struct {
    int       org[3];
    int       dir[3];
    int       ctr[3];
    bit [30:0] half[3];
  } ray_t;

  typedef struct {
    bit        hit;
    bit [30:0] et;
    int        hp[3];
    bit [2:0]  ax;
    bit [2:0]  sg;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] org_x = '0, org_y = '0, org_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
  logic [30:0] half_x = 31'd1, half_y = 31'd1, half_z = 31'd1;
  logic        hit;
  logic [30:0] entry_t;
  logic signed [31:0] hit_x, hit_y, hit_z;
  logic [2:0]  face_axes, face_signs;

  isect_t expected_isects[$];
  int     sent_cnt = 0;
  int     mismatches = 0;
  int     cycles = 0;
  bit     hold_done = 1'b0;

  ray_t   table_rays[$];
  bit     table_typed[$];
  isect_t table_isects[$];

  always #5 clk = ~clk;

  ray_box_slab_intersect i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .origin_x_i   (org_x),
    .origin_y_i   (org_y),
    .origin_z_i   (org_z),
    .dir_x_i      (dir_x),
    .dir_y_i      (dir_y),
    .dir_z_i      (dir_z),
    .center_x_i   (ctr_x),
    .center_y_i   (ctr_y),
    .center_z_i   (ctr_z),
    .half_x_i     (half_x),
    .half_y_i     (half_y),
    .half_z_i     (half_z),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hit_o        (hit),
    .entry_t_o    (entry_t),
    .hit_x_o      (hit_x),
    .hit_y_o      (hit_y),
    .hit_z_o      (hit_z),
    .face_axes_o  (face_axes),
    .face_signs_o (face_signs)
  );

  // slab test on 64 bit integers, same truncation and flooring as the block
  function automatic isect_t slab_predict(ray_t r);
    longint t_in, t_out, n_lo, n_hi, t1, t2, diff, mag;
    longint hp[3];
    longint unsigned bn, bd, l, rr;
    bit outside;
    isect_t o;
    o = '{default: 0};
    t_in = {1'b1, 63'b0};
    t_out = {1'b0, {63{1'b1}}};
    outside = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n_lo = longint'(r.ctr[i]) - longint'(r.half[i]) - longint'(r.org[i]);
      n_hi = longint'(r.ctr[i]) + longint'(r.half[i]) - longint'(r.org[i]);
      if (r.dir[i] != 0) begin
        // signed division truncates toward zero
        t1 = (n_lo * (longint'(1) <<< rbsi_pkg::FRAC_BITS)) / longint'(r.dir[i]);
        t2 = (n_hi * (longint'(1) <<< rbsi_pkg::FRAC_BITS)) / longint'(r.dir[i]);
        if (t1 < t2) begin
          if (t1 > t_in) t_in = t1;
          if (t2 < t_out) t_out = t2;
        end else begin
          if (t2 > t_in) t_in = t2;
          if (t1 < t_out) t_out = t1;
        end
      end else if ((n_lo > 0 && n_hi > 0) || (n_lo < 0 && n_hi < 0)) begin
        outside = 1'b1;
      end
    end
    if (outside || !(t_in > 0 && t_in < t_out)) return o;
    bn = 0;
    bd = 1;
    for (int i = 0; i < 3; i++)
      hp[i] = longint'(r.org[i]) + ((longint'(r.dir[i]) * t_in) >>> rbsi_pkg::FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      diff = hp[i] - longint'(r.ctr[i]);
      mag = diff < 0 ? -diff : diff;
      if (mag > (longint'(1) <<< 33) - 1) mag = (longint'(1) <<< 33) - 1;
      l = longint'(mag) * bd;
      rr = bn * longint'(r.half[i]);
      if (l > rr) begin
        o.ax = 3'b001 << i;
        o.sg = diff < 0 ? (3'b001 << i) : 3'b000;
        bn = mag;
        bd = longint'(r.half[i]);
      end else if (l == rr) begin
        o.ax[i] = 1'b1;
        if (diff < 0) o.sg[i] = 1'b1;
      end
    end
    o.hit = 1'b1;
    o.et = t_in > 64'sh7FFFFFFF ? 31'h7FFFFFFF : t_in[30:0];
    for (int i = 0; i < 3; i++) begin
      if (hp[i] > 64'sd2147483647) o.hp[i] = 32'h7FFFFFFF;
      else if (hp[i] < -64'sd2147483648) o.hp[i] = 32'h80000000;
      else o.hp[i] = hp[i][31:0];
    end
    return o;
  endfunction

  function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                  int cx, int cy, int cz, int hx, int hy, int hz);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.ctr = '{cx, cy, cz};
    r.half = '{hx[30:0], hy[30:0], hz[30:0]};
    return r;
  endfunction

  function automatic longint span(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // mostly rays aimed at the box from outside, some pure noise
  function automatic ray_t shaped_ray();
    ray_t r;
    int s;
    longint c, h, o, tg;
    if ($urandom_range(0, 9) < 2) begin
      for (int i = 0; i < 3; i++) begin
        r.org[i] = $urandom;
        r.dir[i] = $urandom;
        r.ctr[i] = $urandom;
        r.half[i] = 31'($urandom);
        if (r.half[i] == 0) r.half[i] = 31'd1;
      end
      return r;
    end
    s = $urandom_range(4, 24);
    for (int i = 0; i < 3; i++) begin
      c = span(longint'(1) << (s + 2));
      h = $urandom_range(1, 1 << s);
      o = c + span(longint'(1) << (s + 4));
      tg = c + span(h + 4);
      r.org[i] = 32'(o);
      r.ctr[i] = 32'(c);
      r.half[i] = 31'(h);
      r.dir[i] = $urandom_range(0, 7) == 0 ? 0 : 32'((tg - o) >>> $urandom_range(0, 6));
    end
    return r;
  endfunction

  task automatic add_row(ray_t r, bit typed, isect_t e);
    table_rays.push_back(r);
    table_typed.push_back(typed);
    table_isects.push_back(e);
  endtask

  task automatic build_table();
    isect_t miss, e;
    miss = '{default: 0};
    // straight hit on the -x face of a unit cube
    e = '{hit: 1'b1, et: 31'd589824, hp: '{-Q, 0, 0}, ax: 3'b001, sg: 3'b001};
    add_row(mk_ray(-10*Q, 0, 0, Q, 0, 0, 0, 0, 0, Q, Q, Q), 1'b1, e);
    // all direction components zero
    add_row(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, Q, Q, Q), 1'b1, miss);
    // zero direction with origin strictly outside that slab
    add_row(mk_ray(-10*Q, 5*Q, 0, Q, 0, 0, 0, 0, 0, Q, Q, Q), 1'b1, miss);
    // pointing away from the box
    add_row(mk_ray(-10*Q, 0, 0, -Q, 0, 0, 0, 0, 0, Q, Q, Q), 1'b1, miss);
    // origin inside the box, entry behind it
    add_row(mk_ray(0, 0, 0, Q, Q, Q, 0, 0, 0, Q, Q, Q), 1'b1, miss);
    // entry exactly zero, origin on the face
    add_row(mk_ray(-Q, 0, 0, Q, 0, 0, 0, 0, 0, Q, Q, Q), 1'b1, miss);
    // diagonal into the corner, faces tie
    add_row(mk_ray(-5*Q, -5*Q, -5*Q, Q, Q, Q, 0, 0, 0, Q, Q, Q), 1'b0, miss);
    add_row(mk_ray(5*Q, 5*Q, -5*Q, -Q, -Q, Q, 0, 0, 0, Q, Q, Q), 1'b0, miss);
    // diagonal ray entering through the -x face, entry before exit
    add_row(mk_ray(-3*Q, -Q, 0, Q, Q, 0, 0, Q, 0, Q, Q, Q), 1'b0, miss);
    // tiny direction, saturated entry and far hit point
    add_row(mk_ray(32'h80000000, 0, 0, 1, 0, 0, 0, 0, 0, Q, Q, Q), 1'b0, miss);
    add_row(mk_ray(32'h80000000, 0, 0, 1, 1, 0, 0, 32'h7FFF0000, 0, Q, 31'h7FFFFFFF, Q),
            1'b0, miss);
    // extremes of every field
    add_row(mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF), 1'b0, miss);
    add_row(mk_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000,
                   31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF), 1'b0, miss);
    add_row(mk_ray(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 1, 1, 1), 1'b0, miss);
    add_row(mk_ray(-1, -1, -1, 32'h80000000, -1, 1, 0, 0, 0, 31'h7FFFFFFF, 1, 1),
            1'b0, miss);
    // zero half size, with and without a zero direction
    add_row(mk_ray(-10*Q, 0, 0, Q, 0, 0, 0, 0, 0, Q, 0, Q), 1'b0, miss);
    add_row(mk_ray(-10*Q, 0, 0, Q, Q, 0, 0, 0, 0, Q, 0, Q), 1'b0, miss);
    add_row(mk_ray(-10*Q, 0, 0, Q, 0, 0, 0, 0, 0, 0, Q, Q), 1'b0, miss);
  endtask

  // offer one request, hold it until accepted, then log what it must produce
  task automatic send_ray(ray_t r, bit typed, isect_t e);
    org_x <= r.org[0]; org_y <= r.org[1]; org_z <= r.org[2];
    dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
    ctr_x <= r.ctr[0]; ctr_y <= r.ctr[1]; ctr_z <= r.ctr[2];
    half_x <= r.half[0]; half_y <= r.half[1]; half_z <= r.half[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_isects.push_back(typed ? e : slab_predict(r));
    sent_cnt++;
    // random idle burst between requests, none near the end
    if (sent_cnt < QUIET_AT && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // request side
  initial begin
    isect_t none;
    none = '{default: 0};
    build_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rays[k]) send_ray(table_rays[k], table_typed[k], table_isects[k]);
    repeat (N_RANDOM) send_ray(shaped_ray(), 1'b0, none);
    in_valid <= 1'b0;
    while (expected_isects.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stall bursts, plus one long hold so the block backs up
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_ready <= 1'b1;
      end else if (sent_cnt < QUIET_AT && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    isect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_isects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, nothing pending");
      end else begin
        e = expected_isects.pop_front();
        if (hit !== e.hit || entry_t !== e.et || hit_x !== e.hp[0] || hit_y !== e.hp[1] ||
            hit_z !== e.hp[2] || face_axes !== e.ax || face_signs !== e.sg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d %b %b got %0d %0d %0d %0d %0d %b %b",
                     e.hit, e.et, e.hp[0], e.hp[1], e.hp[2], e.ax, e.sg,
                     hit, entry_t, hit_x, hit_y, hit_z, face_axes, face_signs);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
design/rbsi_pkg.sv
design/rbsi_div.sv
design/rbsi_front.sv
design/rbsi_fifo.sv
design/rbsi_back.sv
design/ray_box_slab_intersect.sv
verif/ray_box_slab_intersect_tb.sv
